>>> rtl/core/assert_macros.svh
// Assertion macros used by the FIR filter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every clock edge outside reset.
`define FIR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Implication checked on the same edge.
`define FIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Implication checked on the following edge.
`define FIR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/core/fir_pkg.sv
// Shared types and constants for the direct-form FIR filter.
// No dependencies; imported by fir_cell and fir_filter_direct_form.
`default_nettype none

package fir_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 35;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int NUM_WEIGHTS = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Partial sum travelling down the row of cells.
  typedef struct packed {
    logic vld;
    acc_t sum;
  } psum_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic shift;    // a new sample enters the history
    logic advance;  // partial sums move one cell on
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/fir_cell.sv
// One tap of the FIR filter: a history register and a multiply-accumulate stage.
// Depends on fir_pkg for the sample, sum and control types.
`default_nettype none

module fir_cell
  import fir_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire sample_t   sample_prev,
  output sample_t        sample_o,
  input  wire sample_t   weight,
  input  wire psum_t     psum_i,
  output psum_t          psum_o
);

  sample_t                     sample_r, sample_nxt;
  logic                        vld_r, vld_nxt;
  acc_t                        sum_r, sum_nxt;
  logic signed [PROD_W-1:0]    prod;

  // History: take the neighbor's sample when a new sample arrives.
  always_comb begin
    sample_nxt = ctl.shift ? sample_prev : sample_r;
  end

  // Multiply this tap and add to the partial sum from the left.
  always_comb begin
    prod    = PROD_W'(weight) * PROD_W'(sample_r);
    vld_nxt = ctl.advance ? psum_i.vld : vld_r;
    sum_nxt = ctl.advance ? (psum_i.sum + ACC_W'(prod)) : sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      vld_r    <= 1'b0;
    end else begin
      sample_r <= sample_nxt;
      vld_r    <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sample_o   = sample_r;
  assign psum_o.vld = vld_r;
  assign psum_o.sum = sum_r;

endmodule

`default_nettype wire

>>> rtl/core/fir_filter_direct_form.sv
// Top level of the direct-form FIR filter: weight registers, control and output stage.
// Depends on fir_pkg, fir_cell and assert_macros.svh.
//
// Usage:
//   Samples arrive as beats on the in_ stream (signed 16 bits in in_tdata[15:0]).
//   Each accepted beat yields exactly one beat on the out_ stream carrying the
//   signed 35-bit sum of tap_weight_k times the sample k steps back.
//   Weights are written through cfg_wr_en / cfg_index / cfg_wdata while idle;
//   indexes 0..7 select tap_weight_0..7, others are ignored.
//   A row of TAPS cells holds the sample history; a partial sum walks down the
//   row one cell per cycle, each cell adding its product.
//   An accepted sample is registered in the history and the start flag; its
//   partial sum passes each cell's sum register, then the output register.
//   No new sample is taken before the previous sum moves to the output register.
//   Reset (synchronous, rst_n low) clears the history, the weights and all
//   valid flags.
//   If the receiver stalls, the finished result is held in the output
//   register; a following sample is still taken and its partial sum waits at
//   the end of the row until the output register frees up.
`default_nettype none

module fir_filter_direct_form
  import fir_pkg::*;
#(
  parameter int TAPS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample_in
  // Result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [34:0] filtered_out, [39:35] zero
  // Configuration port
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [SAMPLE_W-1:0]    cfg_wdata
);

  `include "assert_macros.svh"

  sample_t    weight_r [NUM_WEIGHTS];
  sample_t    hist     [TAPS];
  psum_t      psum_c   [TAPS+1];
  logic [TAPS-1:0] vld_vec;

  logic       busy_r, busy_nxt;
  logic       start_r, start_nxt;
  logic       out_vld_r, out_vld_nxt;
  acc_t       out_sum_r;
  logic       in_accept, last_vld, out_free, finish;
  cell_ctl_t  ctl;

  // Weight registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_r[i] <= '0;
      end
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_WEIGHTS))) begin
      weight_r[cfg_index[$clog2(NUM_WEIGHTS)-1:0]] <= cfg_wdata;
    end
  end

  // Handshake and sequencing of one partial-sum walk.
  always_comb begin
    last_vld    = psum_c[TAPS].vld;
    out_free    = !out_vld_r || out_tready;
    finish      = last_vld && out_free;
    in_tready   = !busy_r || finish;
    in_accept   = in_tvalid && in_tready;
    ctl.shift   = in_accept;
    ctl.advance = !last_vld || out_free;
    busy_nxt    = in_accept ? 1'b1 : (finish ? 1'b0 : busy_r);
    start_nxt   = in_accept || (start_r && !ctl.advance);
    out_vld_nxt = finish ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      start_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      start_r   <= start_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (finish) begin
      out_sum_r <= psum_c[TAPS].sum;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-ACC_W){1'b0}}, out_sum_r};

  // Head of the row: an empty partial sum starts the walk.
  assign psum_c[0].vld = start_r;
  assign psum_c[0].sum = '0;

  // Row of cells.
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    sample_t prev;
    if (k == 0) begin : g_head
      assign prev = sample_t'(in_tdata[SAMPLE_W-1:0]);
    end else begin : g_body
      assign prev = hist[k-1];
    end

    fir_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .sample_prev (prev),
      .sample_o    (hist[k]),
      .weight      (weight_r[k]),
      .psum_i      (psum_c[k]),
      .psum_o      (psum_c[k+1])
    );

    assign vld_vec[k] = psum_c[k+1].vld;
  end

  // Only one partial sum is ever walking the row.
  `FIR_ASSERT(a_one_wave, clk, rst_n, $onehot0({vld_vec, start_r}))
  // An accepted sample always leaves a walk in progress.
  `FIR_ASSERT_NXT(a_accept_busy, clk, rst_n, in_accept, busy_r)
  // With no walk in progress the row carries no partial sum.
  `FIR_ASSERT_IMP(a_idle_empty, clk, rst_n, !busy_r, (vld_vec == '0) && !start_r)

endmodule

`default_nettype wire

>>> tb/sv/fir_filter_direct_form_test.sv
// Self-checking testbench for fir_filter_direct_form: directed and random sample streams
// with random stalls on both sides, checked against a predictor of the weighted sum.
// Depends on fir_pkg and the fir_filter_direct_form RTL.
`timescale 1ns / 1ps

module fir_filter_direct_form_test;
  import fir_pkg::*;

  localparam int FILTER_TAPS  = 8;
  localparam int REG_TAP_BASE = 0;              // tap_weight_0 sits at this index
  localparam int REG_LAST     = (1 << CFG_IDX_W) - 1;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 95;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = -16'sh8000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [15:0] sample_in
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [34:0] filtered_out, [39:35] zero
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [SAMPLE_W-1:0]    cfg_wdata  = '0;

  // Predictor state: weight registers and the sample history, newest first.
  sample_t weight_regs [NUM_WEIGHTS];
  sample_t staged_weights [NUM_WEIGHTS];
  sample_t history [FILTER_TAPS];
  acc_t    pending_sums [$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  bit          sender_gaps_on = 1'b1;
  int unsigned hold_reqs      = 0;
  int unsigned hold_done      = 0;
  int unsigned stall_left     = 0;
  int unsigned ready_mode     = 0;
  int unsigned mode_left      = 0;

  fir_filter_direct_form #(
    .TAPS(FILTER_TAPS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic void clear_filter_state();
    for (int k = 0; k < NUM_WEIGHTS; k++) weight_regs[k] = '0;
    for (int k = 0; k < FILTER_TAPS; k++) history[k] = '0;
  endfunction

  // Shift one sample into the history and return the full-precision weighted sum.
  function automatic acc_t next_filtered_sum(input sample_t sample);
    longint acc;
    acc = 0;
    for (int k = FILTER_TAPS - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = sample;
    for (int k = 0; k < FILTER_TAPS && k < NUM_WEIGHTS; k++)
      acc += longint'(weight_regs[k]) * longint'(history[k]);
    return acc[ACC_W-1:0];
  endfunction

  // Field values weighted toward the extremes.
  function automatic sample_t pick_value();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return -16'sd1;
      4:       return 16'sd1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // One beat on the configuration port; writes above the last weight are dropped.
  task automatic write_register(input int idx, input sample_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_wdata <= value;
    @(posedge clk);
    if (idx < REG_TAP_BASE + NUM_WEIGHTS) weight_regs[idx - REG_TAP_BASE] = value;
  endtask

  // Write every weight from staged_weights; with_unused also writes junk to the unused indexes.
  task automatic program_weights(input bit with_unused);
    for (int k = 0; k < NUM_WEIGHTS; k++)
      write_register(REG_TAP_BASE + k, staged_weights[k]);
    if (with_unused)
      for (int idx = REG_TAP_BASE + NUM_WEIGHTS; idx <= REG_LAST; idx++)
        write_register(idx, sample_t'($urandom));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one sample, with a random gap at the start of each burst if sender_gaps_on is set.
  task automatic send_sample(input sample_t sample);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = sender_gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_sums.push_back(next_filtered_sum(sample));
  endtask

  // Stop offering and wait until every predicted sum has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall pattern that changes mode now and then, plus long hold-offs on request.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (hold_done != hold_reqs) begin
      hold_done++;
      stall_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (ready_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check each result beat against the oldest predicted sum and its padding bits against zero.
  always @(posedge clk) begin
    acc_t want;
    acc_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[ACC_W-1:0];
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with no sample waiting for it",
                                  $signed(got)));
      end else begin
        want = pending_sums.pop_front();
        if (got !== want)
          report_mismatch($sformatf("filtered_out %0d, predicted %0d",
                                    $signed(got), $signed(want)));
      end
      if (out_tdata[OUT_TDATA_W-1:ACC_W] !== '0)
        report_mismatch($sformatf("padding bits of out_tdata are %b",
                                  out_tdata[OUT_TDATA_W-1:ACC_W]));
    end
  end

  // Distinct weights so that every history slot shows; the first samples see a cleared history.
  task automatic test_early_samples();
    for (int k = 0; k < NUM_WEIGHTS; k++)
      staged_weights[k] = (k % 2 == 0) ? sample_t'(k + 1) : -sample_t'(k + 1);
    program_weights(1'b0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample('0);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);
    send_sample(16'sh0100);
    drain_results();
  endtask

  // Largest positive and largest negative sums.
  task automatic test_extreme_sums();
    for (int k = 0; k < NUM_WEIGHTS; k++) staged_weights[k] = SAMPLE_MIN;
    program_weights(1'b0);
    repeat (FILTER_TAPS) send_sample(SAMPLE_MIN);
    drain_results();
    for (int k = 0; k < NUM_WEIGHTS; k++) staged_weights[k] = SAMPLE_MAX;
    program_weights(1'b0);
    send_sample(SAMPLE_MIN);
    drain_results();
  endtask

  // Writes to indexes past the last weight must leave the weights alone.
  task automatic test_unused_indexes();
    for (int k = 0; k < NUM_WEIGHTS; k++) staged_weights[k] = pick_value();
    program_weights(1'b1);
    send_sample(SAMPLE_MAX);
    send_sample(pick_value());
    drain_results();
  endtask

  // Random samples in phases, each phase with a fresh weight setting.
  task automatic test_random_stream();
    for (int p = 0; p < PHASES; p++) begin
      for (int k = 0; k < NUM_WEIGHTS; k++) begin
        case (p)
          0:       staged_weights[k] = SAMPLE_MAX;
          1:       staged_weights[k] = SAMPLE_MIN;
          2:       staged_weights[k] = (k % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
          default: staged_weights[k] = pick_value();
        endcase
      end
      program_weights(p % 2 == 1);
      sender_gaps_on = (p % 3 != 0);
      repeat (PHASE_ITEMS) send_sample(pick_value());
      drain_results();
    end
    sender_gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    for (int k = 0; k < NUM_WEIGHTS; k++) staged_weights[k] = pick_value();
    program_weights(1'b0);
    sender_gaps_on = 1'b0;
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_sample(pick_value());
    drain_results();
    sender_gaps_on = 1'b1;
  endtask

  initial begin
    clear_filter_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_early_samples();
    test_extreme_sums();
    test_unused_indexes();
    test_backpressure();
    test_random_stream();

    repeat (FILTER_TAPS + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
